/* rtl/core/ofl_pkg.sv */
// Shared types and constants for the overcurrent fault latch.
// Used by the interfaces, the channel lanes, the fault merge and the top level.
`default_nettype none

package ofl_pkg;

  localparam int THR_W    = 12;
  localparam int COUNT_W  = 16;
  localparam int TOTAL_W  = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [COUNT_W-1:0] HOLD_MARGIN = COUNT_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_A    = 3'd0,
    CFG_THRESHOLD_B    = 3'd1,
    CFG_TRIP_WINDOW    = 3'd2,
    CFG_CLEAR_HOLD     = 3'd3,
    CFG_HEARTBEAT_PER  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [COUNT_W-1:0] clear_hold;
    logic [COUNT_W-1:0] heartbeat_period;
  } ofl_cfg_t;

  typedef struct packed {
    logic at_window_a;
    logic at_window_b;
  } ofl_lane_st_t;

  typedef struct packed {
    logic               fault_active;
    logic               drive_enable;
    logic               led_on;
    logic               tripped_now;
    logic               cleared_now;
    logic [TOTAL_W-1:0] trips_total;
  } ofl_result_t;

endpackage

`default_nettype wire

/* rtl/core/ofl_if.sv */
// Valid/ready channel interfaces for sample words and result words.
// Depends on ofl_pkg for field widths.
`default_nettype none

interface ofl_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] current_a;
  logic [SAMPLE_BITS-1:0] current_b;
  logic                   button_down;

  modport source (output valid, current_a, current_b, button_down, input ready);
  modport sink   (input valid, current_a, current_b, button_down, output ready);
endinterface

interface ofl_out_if
  import ofl_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               fault_active;
  logic               drive_enable;
  logic               led_on;
  logic               tripped_now;
  logic               cleared_now;
  logic [TOTAL_W-1:0] trips_total;

  modport source (output valid, fault_active, drive_enable, led_on, tripped_now,
                  cleared_now, trips_total, input ready);
  modport sink   (input valid, fault_active, drive_enable, led_on, tripped_now,
                  cleared_now, trips_total, output ready);
endinterface

`default_nettype wire

/* rtl/core/ofl_lane.sv */
// One channel lane: threshold compare and saturating consecutive-over count.
// Depends on ofl_pkg.
`default_nettype none

module ofl_lane
  import ofl_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   take_i,
  input  wire logic                   clear_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [THR_W-1:0]       threshold_i,
  input  wire logic [COUNT_W-1:0]     window_i,
  output logic                        at_window_o
);

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [COUNT_W-1:0] count_q, count_d;
  logic               over;

  assign over = CMP_W'(sample_i) > CMP_W'(threshold_i);

  always_comb begin
    if (!over) begin
      count_d = '0;
    end else if (&count_q) begin
      count_d = count_q;
    end else begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  assign at_window_o = count_d >= window_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (take_i) begin
      count_q <= clear_i ? '0 : count_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ofl_merge.sv */
// Fault merge: combines lane trip flags, runs the latch, button clear and heartbeat.
// Depends on ofl_pkg.
`default_nettype none

module ofl_merge
  import ofl_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         take_i,
  input  wire logic         button_i,
  input  wire ofl_lane_st_t lane_st_i,
  input  wire ofl_cfg_t     cfg_i,
  output logic              clear_o,
  output ofl_result_t       res_o
);

  logic               in_fault_q, in_fault_d;
  logic               led_q, led_d;
  logic [COUNT_W-1:0] hold_q, hold_d;
  logic [COUNT_W-1:0] beat_q, beat_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic               trip;
  logic               clear;
  logic [COUNT_W:0]   cap_wide;
  logic [COUNT_W-1:0] cap;
  logic [COUNT_W-1:0] hold_inc;
  logic               led_base;
  logic [COUNT_W:0]   beat_next;

  assign trip     = !in_fault_q && (lane_st_i.at_window_a || lane_st_i.at_window_b);
  assign cap_wide = {1'b0, cfg_i.clear_hold} + {1'b0, HOLD_MARGIN};
  assign cap      = cap_wide[COUNT_W] ? '1 : cap_wide[COUNT_W-1:0];
  assign hold_inc = (hold_q < cap) ? hold_q + COUNT_W'(1) : hold_q;
  assign clear    = in_fault_q && button_i && (hold_inc >= cfg_i.clear_hold);

  always_comb begin
    in_fault_d = in_fault_q;
    led_base   = led_q;
    hold_d     = hold_q;
    if (trip) begin
      in_fault_d = 1'b1;
      led_base   = 1'b1;
    end else if (clear) begin
      in_fault_d = 1'b0;
      led_base   = 1'b0;
    end
    if (in_fault_q) begin
      hold_d = (button_i && !clear) ? hold_inc : '0;
    end

    beat_next = {1'b0, beat_q} + (COUNT_W+1)'(1);
    beat_d    = beat_q;
    led_d     = led_base;
    if (!in_fault_d) begin
      if (beat_next >= {1'b0, cfg_i.heartbeat_period}) begin
        beat_d = '0;
        led_d  = !led_base;
      end else begin
        beat_d = beat_next[COUNT_W-1:0];
      end
    end

    total_d = total_q + TOTAL_W'(trip);
  end

  assign clear_o = clear;

  always_comb begin
    res_o.fault_active = in_fault_d;
    res_o.drive_enable = !in_fault_d;
    res_o.led_on       = led_d;
    res_o.tripped_now  = trip;
    res_o.cleared_now  = clear;
    res_o.trips_total  = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fault_q <= 1'b0;
      led_q      <= 1'b0;
      hold_q     <= '0;
      beat_q     <= '0;
      total_q    <= '0;
    end else if (take_i) begin
      in_fault_q <= in_fault_d;
      led_q      <= led_d;
      hold_q     <= hold_d;
      beat_q     <= beat_d;
      total_q    <= total_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/overcurrent_fault_latch_top.sv */
// Top level of the overcurrent fault latch: config registers, two lanes, merge, output register.
// Depends on ofl_pkg, ofl_if, ofl_lane and ofl_merge.
`default_nettype none

// One sample word per clock while the output drains: each accepted word is a tick,
// and its result is presented in the next cycle from a single output register. A new
// word is taken whenever that register is empty or read in the same cycle, so with output
// ready held high the block sustains one word per cycle, limited by the update of the
// channel counters and fault state. The user must write thresholds and windows through
// the config port only while no word is in flight; the block does not enforce this.

module overcurrent_fault_latch_top
  import ofl_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  ofl_in_if.sink                    in_i,
  ofl_out_if.source                 out_o
);

  logic [THR_W-1:0]   thr_a_q, thr_b_q;
  logic [COUNT_W-1:0] window_q, clear_hold_q, hb_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_a_q      <= THR_W'(507);
      thr_b_q      <= THR_W'(507);
      window_q     <= COUNT_W'(50);
      clear_hold_q <= COUNT_W'(1000);
      hb_period_q  <= COUNT_W'(250);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD_A:   thr_a_q      <= cfg_wdata_i[THR_W-1:0];
        CFG_THRESHOLD_B:   thr_b_q      <= cfg_wdata_i[THR_W-1:0];
        CFG_TRIP_WINDOW:   window_q     <= cfg_wdata_i[COUNT_W-1:0];
        CFG_CLEAR_HOLD:    clear_hold_q <= cfg_wdata_i[COUNT_W-1:0];
        CFG_HEARTBEAT_PER: hb_period_q  <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic         out_valid_q;
  logic         take;
  logic         clear;
  ofl_lane_st_t lane_st;
  ofl_cfg_t     cfg;
  ofl_result_t  res_d, res_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;

  assign cfg.clear_hold       = clear_hold_q;
  assign cfg.heartbeat_period = hb_period_q;

  ofl_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .clear_i     (clear),
    .sample_i    (in_i.current_a),
    .threshold_i (thr_a_q),
    .window_i    (window_q),
    .at_window_o (lane_st.at_window_a)
  );

  ofl_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .clear_i     (clear),
    .sample_i    (in_i.current_b),
    .threshold_i (thr_b_q),
    .window_i    (window_q),
    .at_window_o (lane_st.at_window_b)
  );

  ofl_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .button_i  (in_i.button_down),
    .lane_st_i (lane_st),
    .cfg_i     (cfg),
    .clear_o   (clear),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.fault_active = res_q.fault_active;
  assign out_o.drive_enable = res_q.drive_enable;
  assign out_o.led_on       = res_q.led_on;
  assign out_o.tripped_now  = res_q.tripped_now;
  assign out_o.cleared_now  = res_q.cleared_now;
  assign out_o.trips_total  = res_q.trips_total;

  a_take_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_q)
    else $error("accepted word did not reach the output register");

  a_trip_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.tripped_now) |-> (res_q.fault_active && !res_q.cleared_now))
    else $error("trip word without latched fault");

  a_clear_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.cleared_now) |-> !res_q.fault_active)
    else $error("clear word with fault still latched");

  a_total_counts_trips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && $past(take) && rst_ni) |=>
      (res_q.trips_total == $past(res_q.trips_total) + TOTAL_W'(res_q.tripped_now)))
    else $error("trip total out of step with trips");

endmodule

`default_nettype wire
